### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, held off while reset is high.
`define CHECK_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication that must hold in the same cycle.
`define CHECK_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication that must hold in the following cycle.
`define CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/hlrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hlrd_pkg;

   localparam int PhaseW = 3;
   localparam int LenW   = 16;

   localparam logic [PhaseW-1:0] PH_KIND    = 3'd0;
   localparam logic [PhaseW-1:0] PH_LEN1    = 3'd1;
   localparam logic [PhaseW-1:0] PH_LEN2    = 3'd2;
   localparam logic [PhaseW-1:0] PH_LEN3    = 3'd3;
   localparam logic [PhaseW-1:0] PH_LEN4    = 3'd4;
   localparam logic [PhaseW-1:0] PH_PAYLOAD = 3'd5;

   localparam logic [1:0] EV_BYTE  = 2'd0;
   localparam logic [1:0] EV_EMPTY = 2'd1;
   localparam logic [1:0] EV_CLEAN = 2'd2;
   localparam logic [1:0] EV_ERROR = 2'd3;

   localparam logic [1:0] KIND_A       = 2'd0;
   localparam logic [1:0] KIND_F       = 2'd1;
   localparam logic [1:0] KIND_S       = 2'd2;
   localparam logic [1:0] KIND_UNKNOWN = 2'd3;

   localparam logic [7:0] CHAR_A = 8'h61;
   localparam logic [7:0] CHAR_F = 8'h66;
   localparam logic [7:0] CHAR_S = 8'h73;

   localparam logic [2:0] ENABLE_RESET = 3'd7;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       stream_end;
   } req_type;

   typedef struct packed {
      logic [1:0] event_res;
      logic [1:0] channel;
      logic [7:0] data_byte;
      logic       last_of_record;
   } rsp_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.valid = 1'b1;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.value = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.value = 4'(c - 8'h57);
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

endpackage

`default_nettype wire

### design/hex_length_record_deframer.sv
// Beats pass the input register, then the output register. Throughput: one input
// beat per cycle while results are taken. While a result waits, the input register
// takes one more beat and then holds req_ready low until the result is taken.
// Reset (synchronous, active high) returns the parser to the kind byte,
// clears the stop flag and the length state, and sets enable_ff to 7.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module hex_length_record_deframer
   import hlrd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic [2:0] csr_data
);

   logic              in_valid_ff, in_valid_in;
   req_type           in_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic [2:0]        enable_ff;

   logic [PhaseW-1:0] phase_ff, phase_in;
   logic [1:0]        kind_ff, kind_in;
   logic [LenW-1:0]   length_ff, length_in;
   logic              digits_ended_ff, digits_ended_in;
   logic [LenW-1:0]   bytes_left_ff, bytes_left_in;
   logic              stopped_ff, stopped_in;

   logic              out_free;
   logic              in_move;
   logic              emit;
   rsp_type           res;
   hex_type           hex;
   logic [LenW-1:0]   len_next;
   logic [LenW-1:0]   left_next;
   logic [1:0]        kind_byte;
   logic              kind_enabled;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign in_move   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      hex       = hex_decode(in_data_ff.in_byte);
      left_next = bytes_left_ff - LenW'(1);
      len_next  = length_ff;
      if (hex.valid && !digits_ended_ff) begin
         len_next = {length_ff[LenW-5:0], hex.value};
      end
      case (in_data_ff.in_byte)
         CHAR_A:  kind_byte = KIND_A;
         CHAR_F:  kind_byte = KIND_F;
         CHAR_S:  kind_byte = KIND_S;
         default: kind_byte = KIND_UNKNOWN;
      endcase
      kind_enabled = (kind_ff != KIND_UNKNOWN) && enable_ff[kind_ff];
   end

   always_comb begin
      phase_in        = phase_ff;
      kind_in         = kind_ff;
      length_in       = length_ff;
      digits_ended_in = digits_ended_ff;
      bytes_left_in   = bytes_left_ff;
      stopped_in      = stopped_ff;
      emit            = 1'b0;
      res             = '0;
      if (in_move && !stopped_ff) begin
         if (in_data_ff.stream_end) begin
            emit          = 1'b1;
            stopped_in    = 1'b1;
            res.event_res = (phase_ff == PH_PAYLOAD) ? EV_ERROR : EV_CLEAN;
         end else begin
            unique case (phase_ff) inside
               PH_KIND: begin
                  kind_in         = kind_byte;
                  length_in       = '0;
                  digits_ended_in = 1'b0;
                  phase_in        = PH_LEN1;
               end
               PH_LEN1, PH_LEN2, PH_LEN3, PH_LEN4: begin
                  if (!hex.valid && phase_ff == PH_LEN1) begin
                     emit          = 1'b1;
                     stopped_in    = 1'b1;
                     res.event_res = EV_CLEAN;
                  end else begin
                     length_in = len_next;
                     if (!hex.valid) begin
                        digits_ended_in = 1'b1;
                     end
                     if (phase_ff != PH_LEN4) begin
                        phase_in = phase_ff + PhaseW'(1);
                     end else if (len_next == '0) begin
                        phase_in = PH_KIND;
                        if (kind_ff == KIND_UNKNOWN) begin
                           emit          = 1'b1;
                           stopped_in    = 1'b1;
                           res.event_res = EV_ERROR;
                        end else if (kind_enabled) begin
                           emit          = 1'b1;
                           res.event_res = EV_EMPTY;
                           res.channel   = kind_ff;
                        end
                     end else begin
                        bytes_left_in = len_next;
                        phase_in      = PH_PAYLOAD;
                     end
                  end
               end
               default: begin
                  bytes_left_in = left_next;
                  if (left_next == '0) begin
                     phase_in = PH_KIND;
                  end
                  if (kind_ff == KIND_UNKNOWN) begin
                     if (left_next == '0) begin
                        emit          = 1'b1;
                        stopped_in    = 1'b1;
                        res.event_res = EV_ERROR;
                     end
                  end else if (kind_enabled) begin
                     emit               = 1'b1;
                     res.event_res      = EV_BYTE;
                     res.channel        = kind_ff;
                     res.data_byte      = in_data_ff.in_byte;
                     res.last_of_record = (left_next == '0);
                  end
               end
            endcase
         end
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = emit;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         enable_ff       <= ENABLE_RESET;
         phase_ff        <= PH_KIND;
         kind_ff         <= KIND_A;
         length_ff       <= '0;
         digits_ended_ff <= 1'b0;
         bytes_left_ff   <= '0;
         stopped_ff      <= 1'b0;
      end else begin
         in_valid_ff     <= in_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         phase_ff        <= phase_in;
         kind_ff         <= kind_in;
         length_ff       <= length_in;
         digits_ended_ff <= digits_ended_in;
         bytes_left_ff   <= bytes_left_in;
         stopped_ff      <= stopped_in;
         if (csr_valid && csr_ready) begin
            enable_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

   `CHECK_NEXT(a_stop_sticks, clock, reset, stopped_ff, stopped_ff, "stop flag cleared without reset")
   `CHECK_SAME(a_stop_reported, clock, reset, $rose(stopped_ff), rsp_valid_ff && (rsp_data_ff.event_res == EV_CLEAN || rsp_data_ff.event_res == EV_ERROR), "stream stopped without an end result")
   `CHECK_SAME(a_payload_count, clock, reset, phase_ff == PH_PAYLOAD, bytes_left_ff != '0, "payload phase with no bytes left")
   `CHECK_SAME(a_last_is_byte, clock, reset, rsp_valid_ff && rsp_data_ff.last_of_record, rsp_data_ff.event_res == EV_BYTE, "last flag on a result that is not a payload byte")

endmodule

`default_nettype wire
